// ===== design/grid_nearest_neighbor_search_macros.svh =====
// ----------------------------------------------------------------------------
// grid nearest neighbour search assertion macros
// shared concurrent assertion forms, sampled on clk and idle in reset
// ----------------------------------------------------------------------------
`ifndef GRID_NEAREST_NEIGHBOR_SEARCH_MACROS_SVH
`define GRID_NEAREST_NEIGHBOR_SEARCH_MACROS_SVH

`ifndef SYNTH
`define GNNS_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gnns assertion failed");
`define GNNS_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gnns assertion failed");
`else
`define GNNS_ASSERT_IMP(name, cond, prop)
`define GNNS_ASSERT_NXT(name, cond, prop)
`endif

`endif

// ===== design/gnns_pkg.sv =====
// ----------------------------------------------------------------------------
// gnns_pkg
// grid geometry, field widths, codes and divider interface types
// ----------------------------------------------------------------------------
package gnns_pkg;

    localparam int HALF_CELLS      = 15;
    localparam int POINTS_PER_CELL = 8;
    localparam int MAX_RADIUS      = 4;

    localparam int GRID_SIDE  = 2 * HALF_CELLS + 1;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int PT_DEPTH   = GRID_CELLS * POINTS_PER_CELL;

    localparam int CELL_AW = $clog2(GRID_CELLS);
    localparam int PT_AW   = $clog2(PT_DEPTH);
    localparam int IDX_W   = $clog2(GRID_SIDE);
    localparam int CNT_W   = $clog2(POINTS_PER_CELL + 1);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 2);
    localparam int CI_W    = $clog2(GRID_SIDE + MAX_RADIUS + 1) + 1;

    localparam int COORD_W = 32;
    localparam int DIM_W   = 31;
    localparam int ROT_W   = 16;
    localparam int DIST_W  = 64;
    localparam int MUL_W   = 33;
    localparam int PT_W    = 2 * COORD_W;

    localparam int IN_DATA_W  = 4 * COORD_W + 2 * ROT_W;
    localparam int OUT_DATA_W = 2 * COORD_W + DIST_W;

    localparam logic [DIM_W-1:0] CELL_SIZE_RESET = 31'd3277;
    localparam logic [DIM_W-1:0] DIST_THR_RESET  = 31'd13107;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic {
        REG_CELL_SIZE = 1'b0,
        REG_DIST_THR  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [DIM_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/gnns_ram.sv =====
// ----------------------------------------------------------------------------
// gnns_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gnns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/gnns_div.sv =====
// ----------------------------------------------------------------------------
// gnns_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gnns_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gnns_pkg::div_req_t req,
    output gnns_pkg::div_rsp_t rsp
);

    import gnns_pkg::*;

    localparam int STEP_W = $clog2(COORD_W + 1);

    logic [STEP_W-1:0]  step_reg;
    logic               done_reg;
    logic [DIM_W-1:0]   rem_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [DIM_W-1:0]   dvs_reg;

    logic [COORD_W-1:0] rem_sh;
    logic [COORD_W-1:0] rem_sub;
    logic               fits;

    assign rem_sh  = {rem_reg, quo_reg[COORD_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            step_reg <= STEP_W'(COORD_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
            quo_reg <= {quo_reg[COORD_W-2:0], fits};
        end
    end

    assign rsp.busy     = (step_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/grid_nearest_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// grid_nearest_neighbor_search
// point binning and nearest neighbour query over a square uniform grid
// ----------------------------------------------------------------------------
// s_ channel: one item per transfer; s_tuser[0] selects add (0) or query (1),
//   s_tdata carries the point and, for a query, the pose.
// m_ channel: exactly one result per item; m_tuser holds the status code,
//   m_tdata the neighbour and its squared distance (zero unless found).
// cfg port: cfg_addr 0 writes cell size, 1 the distance threshold; the user
//   must write it only while no item is in flight; the block does not enforce this.
// items are handled one at a time by a sequencer around one shared
// multiplier and one bit-serial divider.
// an add runs two cell index divisions, a count read when the point lies
// on the grid, the output load and the return to idle.
// a query does the rotation, then the cell x and cell y divisions and, on
// the grid, the radius division, then scans the (2R+1)^2 window row by row,
// reading the count of each on-grid cell and then each stored point.
// after reset the cell count memory is cleared in a pass over all 961 cells,
// during which s_tready stays low.
// the result sits in an output register; the next item is taken while it
// waits, but its own result is held back until m_tready frees the register.
// ----------------------------------------------------------------------------
`include "grid_nearest_neighbor_search_macros.svh"

module grid_nearest_neighbor_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, pose_x, pose_y, pose_cos, pose_sin
    input  logic [gnns_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // nearest_x, nearest_y, nearest_dist_sq
    output logic [gnns_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [gnns_pkg::DIM_W-1:0]        cfg_wdata
);

    import gnns_pkg::*;

    typedef enum logic [17:0] {
        S_CLEAR   = 18'(1) << 0,
        S_IDLE    = 18'(1) << 1,
        S_XF      = 18'(1) << 2,
        S_DIVX    = 18'(1) << 3,
        S_DIVY    = 18'(1) << 4,
        S_DIVR    = 18'(1) << 5,
        S_THR     = 18'(1) << 6,
        S_ADD_RD  = 18'(1) << 7,
        S_ADD_CHK = 18'(1) << 8,
        S_CELL    = 18'(1) << 9,
        S_CNT_WT  = 18'(1) << 10,
        S_PT_RD   = 18'(1) << 11,
        S_PT_WT   = 18'(1) << 12,
        S_SQ_X    = 18'(1) << 13,
        S_SQ_Y    = 18'(1) << 14,
        S_SUM     = 18'(1) << 15,
        S_CMP     = 18'(1) << 16,
        S_OUT     = 18'(1) << 17
    } state_t;

    function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [36:0] v);
        logic [COORD_W-1:0] res;
        if (v > 37'sh0_7FFF_FFFF)
            res = 32'h7FFF_FFFF;
        else if (v < -37'sh0_8000_0000)
            res = 32'h8000_0000;
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0]   cell_size_reg;
    logic [DIM_W-1:0]   dist_thr_reg;
    logic [DIM_W-1:0]   eff_cs;
    logic [CELL_AW-1:0] clr_reg;

    logic                     op_reg;
    logic [COORD_W-1:0]       px_reg;
    logic [COORD_W-1:0]       py_reg;
    logic signed [COORD_W-1:0] posx_reg;
    logic signed [COORD_W-1:0] posy_reg;
    logic signed [ROT_W-1:0]  cos_reg;
    logic signed [ROT_W-1:0]  sin_reg;
    logic [2:0]               xf_cnt_reg;
    logic signed [48:0]       t0_reg;
    logic signed [48:0]       tx_reg;
    logic signed [48:0]       ty_reg;
    logic signed [35:0]       rx_reg;
    logic signed [35:0]       ry_reg;
    logic [COORD_W-1:0]       gx_reg;
    logic [COORD_W-1:0]       gy_reg;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;

    logic               x_ok_reg;
    logic [IDX_W-1:0]   xi_reg;
    logic [IDX_W-1:0]   yi_reg;
    logic [RAD_W-1:0]   r_reg;
    logic [DIST_W-1:0]  thr_sq_reg;
    logic signed [CI_W-1:0] cy_reg;
    logic signed [CI_W-1:0] cx_reg;
    logic [CELL_AW-1:0] cell_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [PT_W-1:0]    e_reg;
    logic signed [MUL_W-1:0] dx_reg;
    logic signed [MUL_W-1:0] dy_reg;
    logic [DIST_W-1:0]  asq_reg;
    logic [DIST_W-1:0]  d_reg;
    logic               found_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [PT_W-1:0]    best_pt_reg;

    status_t            res_status_reg;
    logic [COORD_W-1:0] res_x_reg;
    logic [COORD_W-1:0] res_y_reg;
    logic [DIST_W-1:0]  res_dist_reg;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [COORD_W-1:0] m_x_reg;
    logic [COORD_W-1:0] m_y_reg;
    logic [DIST_W-1:0]  m_dist_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               cnt_we;
    logic [CELL_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CELL_AW-1:0] cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata;
    logic               pt_we;
    logic [PT_AW-1:0]   pt_waddr;
    logic [PT_AW-1:0]   pt_raddr;
    logic [PT_W-1:0]    pt_rdata;

    logic               accept;
    logic               load_out;
    logic               in_op;
    logic [COORD_W-1:0] in_px;
    logic [COORD_W-1:0] in_py;

    logic [COORD_W-1:0] div_q;
    logic               q_ok;
    logic               q_neg;
    logic [IDX_W-1:0]   q_idx;

    logic signed [CI_W-1:0] lim_x;
    logic signed [CI_W-1:0] lim_y;
    logic signed [CI_W-1:0] start_x;
    logic               cell_in;
    logic [CELL_AW-1:0] cell_comb;
    logic [CELL_AW-1:0] add_cell;
    logic [49:0]        rsum_x;
    logic [49:0]        rsum_y;
    logic [64:0]        dsum;
    logic               better;

    localparam logic signed [CI_W-1:0] CI_MAX = CI_W'(2 * HALF_CELLS);

    assign in_op = s_tuser[0];
    assign in_px = s_tdata[COORD_W-1:0];
    assign in_py = s_tdata[2*COORD_W-1:COORD_W];

    assign eff_cs = (cell_size_reg == '0) ? DIM_W'(1) : cell_size_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // cell index from the divider quotient
    assign div_q = div_rsp.quotient;
    assign q_ok  = div_q <= COORD_W'(HALF_CELLS);
    assign q_neg = (state_reg == S_DIVX) ? gx_reg[COORD_W-1] : gy_reg[COORD_W-1];
    assign q_idx = q_neg ? (IDX_W'(HALF_CELLS) - div_q[IDX_W-1:0])
                         : (IDX_W'(HALF_CELLS) + div_q[IDX_W-1:0]);

    assign add_cell = CELL_AW'(CELL_AW'(q_idx) * CELL_AW'(GRID_SIDE) + CELL_AW'(xi_reg));

    // search window bounds
    assign lim_x   = CI_W'(xi_reg) + CI_W'(r_reg);
    assign lim_y   = CI_W'(yi_reg) + CI_W'(r_reg);
    assign start_x = CI_W'(xi_reg) - CI_W'(r_reg);
    assign cell_in = (cx_reg >= 0) && (cx_reg <= CI_MAX) && (cy_reg >= 0) && (cy_reg <= CI_MAX);
    assign cell_comb = CELL_AW'(CELL_AW'(cy_reg[IDX_W-1:0]) * CELL_AW'(GRID_SIDE)
                       + CELL_AW'(cx_reg[IDX_W-1:0]));

    // round half up by 2^14
    assign rsum_x = {tx_reg[48], tx_reg} + 50'd8192;
    assign rsum_y = {ty_reg[48], ty_reg} + 50'd8192;

    assign dsum   = {1'b0, asq_reg} + {1'b0, prod_reg[DIST_W-1:0]};
    assign better = (!found_reg || (d_reg < best_reg)) && (d_reg < thr_sq_reg);

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag32(gy_reg);
        div_req.divisor  = eff_cs;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CELL_AW'(GRID_CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_ADD)
                    begin
                        state_next       = S_DIVX;
                        div_req.start    = 1'b1;
                        div_req.dividend = mag32(in_px);
                    end
                    else
                    begin
                        state_next = S_XF;
                    end
                end
            end
            S_XF:
            begin
                if (xf_cnt_reg == 3'd7)
                begin
                    state_next       = S_DIVX;
                    div_req.start    = 1'b1;
                    div_req.dividend = mag32(gx_reg);
                end
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    state_next    = S_DIVY;
                    div_req.start = 1'b1;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    if (!x_ok_reg || !q_ok)
                        state_next = S_OUT;
                    else if (op_reg == OP_ADD)
                        state_next = S_ADD_RD;
                    else
                    begin
                        state_next       = S_DIVR;
                        div_req.start    = 1'b1;
                        div_req.dividend = COORD_W'(dist_thr_reg);
                    end
                end
            end
            S_DIVR:
            begin
                if (div_rsp.done)
                    state_next = S_THR;
            end
            S_THR:     state_next = S_CELL;
            S_ADD_RD:  state_next = S_ADD_CHK;
            S_ADD_CHK: state_next = S_OUT;
            S_CELL:
            begin
                if (cy_reg > lim_y)
                    state_next = S_OUT;
                else if (cx_reg <= lim_x && cell_in)
                    state_next = S_CNT_WT;
            end
            S_CNT_WT:  state_next = S_PT_RD;
            S_PT_RD:
            begin
                if (k_reg >= n_reg)
                    state_next = S_CELL;
                else
                    state_next = S_PT_WT;
            end
            S_PT_WT:   state_next = S_SQ_X;
            S_SQ_X:    state_next = S_SQ_Y;
            S_SQ_Y:    state_next = S_SUM;
            S_SUM:     state_next = S_CMP;
            S_CMP:     state_next = S_PT_RD;
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:   state_next = S_CLEAR;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_XF:
            begin
                case (xf_cnt_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(cos_reg);
                        mul_b = MUL_W'($signed(px_reg));
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(sin_reg);
                        mul_b = MUL_W'($signed(py_reg));
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(sin_reg);
                        mul_b = MUL_W'($signed(px_reg));
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(cos_reg);
                        mul_b = MUL_W'($signed(py_reg));
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DIVR:
            begin
                mul_a = MUL_W'(dist_thr_reg);
                mul_b = MUL_W'(dist_thr_reg);
            end
            S_SQ_X:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            S_SQ_Y:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory ports
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = cell_reg;
        cnt_wdata = cnt_rdata + 1'b1;
        pt_we     = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = '0;
        end
        else if (state_reg == S_ADD_CHK && cnt_rdata < CNT_W'(POINTS_PER_CELL))
        begin
            cnt_we = 1'b1;
            pt_we  = 1'b1;
        end
    end

    assign cnt_raddr = (state_reg == S_ADD_RD) ? cell_reg : cell_comb;
    assign pt_waddr  = PT_AW'(PT_AW'(cell_reg) * PT_AW'(POINTS_PER_CELL) + PT_AW'(cnt_rdata));
    assign pt_raddr  = PT_AW'(PT_AW'(cell_reg) * PT_AW'(POINTS_PER_CELL) + PT_AW'(k_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
            cell_size_reg <= CELL_SIZE_RESET;
            dist_thr_reg  <= DIST_THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (reg_idx_t'(cfg_addr))
                    REG_CELL_SIZE: cell_size_reg <= cfg_wdata;
                    REG_DIST_THR:  dist_thr_reg  <= cfg_wdata;
                    default:       cell_size_reg <= cell_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg     <= in_op;
                    px_reg     <= in_px;
                    py_reg     <= in_py;
                    posx_reg   <= s_tdata[3*COORD_W-1:2*COORD_W];
                    posy_reg   <= s_tdata[4*COORD_W-1:3*COORD_W];
                    cos_reg    <= s_tdata[4*COORD_W+ROT_W-1:4*COORD_W];
                    sin_reg    <= s_tdata[IN_DATA_W-1:4*COORD_W+ROT_W];
                    gx_reg     <= in_px;
                    gy_reg     <= in_py;
                    xf_cnt_reg <= '0;
                end
            end
            S_XF:
            begin
                xf_cnt_reg <= xf_cnt_reg + 1'b1;
                case (xf_cnt_reg)
                    3'd1: t0_reg <= prod_reg[48:0];
                    3'd2: tx_reg <= t0_reg - prod_reg[48:0];
                    3'd3: t0_reg <= prod_reg[48:0];
                    3'd4: ty_reg <= t0_reg + prod_reg[48:0];
                    3'd5:
                    begin
                        rx_reg <= rsum_x[49:14];
                        ry_reg <= rsum_y[49:14];
                    end
                    3'd6:
                    begin
                        gx_reg <= sat32(37'(posx_reg) + 37'(rx_reg));
                        gy_reg <= sat32(37'(posy_reg) + 37'(ry_reg));
                    end
                    default: t0_reg <= t0_reg;
                endcase
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    x_ok_reg <= q_ok;
                    xi_reg   <= q_idx;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    yi_reg         <= q_idx;
                    cell_reg       <= add_cell;
                    res_status_reg <= ST_OUTSIDE;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_dist_reg   <= '0;
                end
            end
            S_DIVR:
            begin
                if (div_rsp.done)
                    r_reg <= (div_q > COORD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                            : div_q[RAD_W-1:0];
            end
            S_THR:
            begin
                thr_sq_reg <= prod_reg[DIST_W-1:0];
                cy_reg     <= CI_W'(yi_reg) - CI_W'(r_reg);
                cx_reg     <= start_x;
                found_reg  <= 1'b0;
                best_reg   <= '0;
            end
            S_ADD_CHK:
            begin
                res_status_reg <= (cnt_rdata < CNT_W'(POINTS_PER_CELL)) ? ST_FOUND : ST_FULL;
            end
            S_CELL:
            begin
                if (cy_reg > lim_y)
                begin
                    res_status_reg <= found_reg ? ST_FOUND : ST_NONE;
                    res_x_reg      <= found_reg ? best_pt_reg[PT_W-1:COORD_W] : '0;
                    res_y_reg      <= found_reg ? best_pt_reg[COORD_W-1:0] : '0;
                    res_dist_reg   <= found_reg ? best_reg : '0;
                end
                else if (cx_reg > lim_x)
                begin
                    cy_reg <= cy_reg + 1'b1;
                    cx_reg <= start_x;
                end
                else if (cell_in)
                    cell_reg <= cell_comb;
                else
                    cx_reg <= cx_reg + 1'b1;
            end
            S_CNT_WT:
            begin
                n_reg <= (cnt_rdata > CNT_W'(POINTS_PER_CELL)) ? CNT_W'(POINTS_PER_CELL)
                                                               : cnt_rdata;
                k_reg <= '0;
            end
            S_PT_RD:
            begin
                if (k_reg >= n_reg)
                    cx_reg <= cx_reg + 1'b1;
            end
            S_PT_WT:
            begin
                e_reg  <= pt_rdata;
                dx_reg <= MUL_W'($signed(pt_rdata[PT_W-1:COORD_W])) - MUL_W'($signed(gx_reg));
                dy_reg <= MUL_W'($signed(pt_rdata[COORD_W-1:0])) - MUL_W'($signed(gy_reg));
            end
            S_SQ_Y: asq_reg <= prod_reg[DIST_W-1:0];
            S_SUM:  d_reg   <= dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
            S_CMP:
            begin
                k_reg <= k_reg + 1'b1;
                if (better)
                begin
                    found_reg   <= 1'b1;
                    best_reg    <= d_reg;
                    best_pt_reg <= e_reg;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    m_status_reg <= res_status_reg;
                    m_x_reg      <= res_x_reg;
                    m_y_reg      <= res_y_reg;
                    m_dist_reg   <= res_dist_reg;
                end
            end
            default: found_reg <= found_reg;
        endcase
    end

    gnns_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gnns_ram #(
        .WIDTH (CNT_W),
        .DEPTH (GRID_CELLS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    gnns_ram #(
        .WIDTH (PT_W),
        .DEPTH (PT_DEPTH)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata ({px_reg, py_reg}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_dist_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_status_reg;

    `GNNS_ASSERT_IMP(a_cnt_wr_max, cnt_we && state_reg != S_CLEAR,
                     cnt_wdata <= CNT_W'(POINTS_PER_CELL))
    `GNNS_ASSERT_IMP(a_found_below_thr,
                     load_out && res_status_reg == ST_FOUND && op_reg == OP_QUERY,
                     res_dist_reg < thr_sq_reg)
    `GNNS_ASSERT_IMP(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready)
    `GNNS_ASSERT_IMP(a_div_done_state, div_rsp.done,
                     state_reg == S_DIVX || state_reg == S_DIVY || state_reg == S_DIVR)

endmodule
